// ===== rtl/core/bra_pkg.sv =====
package bra_pkg;

    // fixed field widths
    localparam int POS_W     = 10;
    localparam int CNT_W     = 11;
    localparam int SPAN_W    = 11;
    localparam int CFG_W     = 8;
    localparam int WORD_BITS = 32;
    localparam int WBIT_W    = 5;
    localparam int WIDX_W    = 6;

    // bytes in use after reset
    localparam logic [CFG_W-1:0] MAP_BYTES_RST = 8'd128;

    // request opcodes
    typedef enum logic [2:0] {
        OP_SET_BIT   = 3'd0,
        OP_CLR_BIT   = 3'd1,
        OP_SET_RANGE = 3'd2,
        OP_CLR_RANGE = 3'd3,
        OP_READ_BIT  = 3'd4,
        OP_FIND_RUN  = 3'd5
    } opcode_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } bra_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic rd;
        logic proc;
        logic ld_out;
    } bra_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic empty;
        logic last_rd;
        logic hit;
    } bra_status_t;

endpackage

// ===== rtl/core/bra_datapath.sv =====
module bra_datapath #(
    parameter int MAP_BYTES = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [bra_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic [2:0]               opcode,
    input  logic [bra_pkg::POS_W-1:0] bit_pos,
    input  logic [bra_pkg::CNT_W-1:0] bit_count,
    input  bra_pkg::bra_cmd_t        cmd,
    output bra_pkg::bra_status_t     status,
    output logic                     bit_value,
    output logic                     found,
    output logic [bra_pkg::POS_W-1:0] run_start,
    output logic                     error
);
    import bra_pkg::*;

    // only bytes reachable by an 8-bit byte count are stored
    localparam int USED_BYTES = (MAP_BYTES < 255) ? MAP_BYTES : 255;
    localparam int WORDS      = (USED_BYTES + 3) / 4;
    localparam int AW         = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [CFG_W-1:0] BYTE_CAP = CFG_W'(USED_BYTES);

    logic [CFG_W-1:0]     map_bytes_reg;
    logic [2:0]           op_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     cnt_reg;

    logic [WIDX_W-1:0]    rd_word_reg;
    logic [WIDX_W-1:0]    proc_word_reg;
    logic [WIDX_W-1:0]    last_word_reg;
    logic                 dat_vld_reg;

    logic [WORD_BITS-1:0] map_mem [WORDS];
    logic [WORDS-1:0]     word_vld_reg;
    logic [WORD_BITS-1:0] mem_q_reg;
    logic                 mem_q_vld_reg;

    logic [SPAN_W-1:0]    run_reg;
    logic                 bitval_reg;
    logic                 found_reg;
    logic [SPAN_W-1:0]    start_reg;

    logic                 out_bitval_reg;
    logic                 out_found_reg;
    logic [POS_W-1:0]     out_start_reg;
    logic                 out_err_reg;

    logic [CFG_W-1:0]     used_bytes;
    logic [SPAN_W-1:0]    nbits;
    logic [SPAN_W:0]      end_sum;
    logic [SPAN_W-1:0]    end_pos;
    logic [SPAN_W-1:0]    end_eff;
    logic [SPAN_W-1:0]    last_bit;
    logic [CFG_W:0]       nwords;
    logic [WIDX_W-1:0]    first_word;
    logic [WIDX_W-1:0]    last_word;
    logic                 err;
    logic                 empty;
    logic                 is_find;
    logic                 is_write;
    logic                 is_set;

    logic [WORD_BITS-1:0] word;
    logic [SPAN_W-1:0]    base;
    logic                 proc_act;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] wdata;
    logic                 wr_en;

    logic [WORD_BITS-1:0] pf_has [WBIT_W+1];
    logic [WBIT_W-1:0]    pf_idx [WBIT_W+1][WORD_BITS];
    logic [SPAN_W-1:0]    run_len [WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;
    logic [WBIT_W-1:0]    hit_sel;
    logic [SPAN_W-1:0]    hit_start;
    logic                 hit;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_bytes_reg <= MAP_BYTES_RST;
        end
        else if (cfg_wr_en)
        begin
            map_bytes_reg <= cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            pos_reg <= bit_pos;
            cnt_reg <= bit_count;
        end
    end

    // request decode and range check
    always_comb
    begin
        used_bytes = (map_bytes_reg > BYTE_CAP) ? BYTE_CAP : map_bytes_reg;
        nbits      = {used_bytes, 3'b000};
        // range end kept one bit wider so a long count cannot wrap
        end_sum    = {2'b00, pos_reg} + {1'b0, cnt_reg};
        end_pos    = end_sum[SPAN_W-1:0];
        nwords     = ({1'b0, used_bytes} + 9'd3) >> 2;
        is_find    = (op_reg == OP_FIND_RUN);
        is_set     = (op_reg == OP_SET_BIT) || (op_reg == OP_SET_RANGE);
        is_write   = 1'b0;
        err        = 1'b0;
        empty      = 1'b0;
        end_eff    = {1'b0, pos_reg} + SPAN_W'(1);
        case (op_reg)
            OP_SET_BIT, OP_CLR_BIT:
            begin
                is_write = 1'b1;
                err      = ({1'b0, pos_reg} >= nbits);
            end
            OP_READ_BIT:
            begin
                err = ({1'b0, pos_reg} >= nbits);
            end
            OP_SET_RANGE, OP_CLR_RANGE:
            begin
                is_write = 1'b1;
                end_eff  = end_pos;
                err      = (end_sum > {1'b0, nbits});
                empty    = (cnt_reg == '0);
            end
            OP_FIND_RUN:
            begin
                err   = (cnt_reg == '0);
                empty = (used_bytes == '0);
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
        last_bit = end_eff - SPAN_W'(1);
        if (is_find)
        begin
            first_word = '0;
            last_word  = WIDX_W'(nwords - 9'd1);
        end
        else
        begin
            first_word = {1'b0, pos_reg[POS_W-1:WBIT_W]};
            last_word  = last_bit[SPAN_W-1:WBIT_W];
        end
    end

    // word walk counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dat_vld_reg <= 1'b0;
        end
        else
        begin
            dat_vld_reg <= cmd.rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rd_word_reg   <= first_word;
            last_word_reg <= last_word;
        end
        else if (cmd.rd)
        begin
            rd_word_reg <= rd_word_reg + WIDX_W'(1);
        end
        if (cmd.rd)
        begin
            proc_word_reg <= rd_word_reg;
        end
    end

    // word store, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[proc_word_reg[AW-1:0]] <= wdata;
        end
        if (cmd.rd)
        begin
            mem_q_reg <= map_mem[rd_word_reg[AW-1:0]];
        end
    end

    // written-word flags, an unwritten word reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_vld_reg  <= '0;
            mem_q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                word_vld_reg[proc_word_reg[AW-1:0]] <= 1'b1;
            end
            if (cmd.rd)
            begin
                mem_q_vld_reg <= word_vld_reg[rd_word_reg[AW-1:0]];
            end
        end
    end

    // range write of the current word
    always_comb
    begin
        word     = mem_q_vld_reg ? mem_q_reg : '0;
        base     = {proc_word_reg, {WBIT_W{1'b0}}};
        proc_act = dat_vld_reg && cmd.proc;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            wmask[j] = ((base + SPAN_W'(j)) >= {1'b0, pos_reg}) &&
                       ((base + SPAN_W'(j)) < end_eff);
        end
        wdata = is_set ? (word | wmask) : (word & ~wmask);
        wr_en = proc_act && is_write;
    end

    // first-fit search over one word: distance to the last busy bit
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pf_has[0][j] = word[j];
            pf_idx[0][j] = WBIT_W'(j);
        end
        for (int l = 0; l < WBIT_W; l++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if ((j >= (1 << l)) && !pf_has[l][j])
                begin
                    pf_has[l+1][j] = pf_has[l][j - (1 << l)];
                    pf_idx[l+1][j] = pf_idx[l][j - (1 << l)];
                end
                else
                begin
                    pf_has[l+1][j] = pf_has[l][j];
                    pf_idx[l+1][j] = pf_idx[l][j];
                end
            end
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (pf_has[WBIT_W][j])
            begin
                run_len[j] = SPAN_W'(j) - SPAN_W'(pf_idx[WBIT_W][j]);
            end
            else
            begin
                run_len[j] = run_reg + SPAN_W'(j) + SPAN_W'(1);
            end
            hit_vec[j] = ((base + SPAN_W'(j)) < nbits) && (run_len[j] >= cnt_reg);
        end
        hit_sel = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (hit_vec[j])
            begin
                hit_sel = WBIT_W'(j);
            end
        end
        hit_start = base + SPAN_W'(hit_sel) + SPAN_W'(1) - cnt_reg;
        hit       = proc_act && is_find && (hit_vec != '0);
    end

    // per-item results
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            run_reg    <= '0;
            bitval_reg <= 1'b0;
            found_reg  <= 1'b0;
            start_reg  <= '0;
        end
        else if (proc_act)
        begin
            if (op_reg == OP_READ_BIT)
            begin
                bitval_reg <= word[pos_reg[WBIT_W-1:0]];
            end
            if (is_find)
            begin
                run_reg <= run_len[WORD_BITS-1];
                if (hit)
                begin
                    found_reg <= 1'b1;
                    start_reg <= hit_start;
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            out_bitval_reg <= bitval_reg && !err;
            out_found_reg  <= found_reg && !err;
            out_start_reg  <= err ? '0 : start_reg[POS_W-1:0];
            out_err_reg    <= err;
        end
    end

    assign status.err     = err;
    assign status.empty   = empty;
    assign status.last_rd = (rd_word_reg == last_word_reg);
    assign status.hit     = hit;

    assign bit_value = out_bitval_reg;
    assign found     = out_found_reg;
    assign run_start = out_start_reg;
    assign error     = out_err_reg;

    // a hit comes only from a find
    a_hit_find: assert property (@(posedge clk) disable iff (!rst_n)
        status.hit |-> (op_reg == OP_FIND_RUN))
        else $error("search hit outside a find");

    // writes stay inside the stored words
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(proc_word_reg) < WORDS))
        else $error("word write beyond store");

    // a rejected request never writes the store
    a_err_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !err)
        else $error("store written by a rejected request");

endmodule

// ===== rtl/core/bra_ctrl.sv =====
module bra_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  bra_pkg::bra_status_t status,
    output bra_pkg::bra_cmd_t    cmd
);
    import bra_pkg::*;

    bra_state_t state_reg;
    bra_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // state and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (status.err || status.empty)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.rd   = 1'b1;
                cmd.proc = 1'b1;
                if (status.hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.last_rd)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.proc   = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.ld_out     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    // a result never overwrites one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |-> (!out_valid_reg || !out_stall))
        else $error("result register overrun");

    // an accepted item always goes to decode
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_DECODE))
        else $error("accepted item not decoded");

    // a result load returns to idle with the result marked valid
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("result load without return to idle");

endmodule

// ===== rtl/core/bitmap_run_allocator_top.sv =====
// First-fit allocation bitmap. One bit per resource (1 = in use), kept in a
// memory of 32-bit words; map_bytes selects how many bytes of the map are in
// use (capped at MAP_BYTES, and at 255 by the register width). Each item sets,
// clears or reads one bit, sets or clears a range, or finds the lowest run of
// bit_count free bits, and gives exactly one result item. A rejected item, an
// empty range or a find on an empty map goes from decode straight to the
// result; otherwise the item walks the memory words that it touches:
// one for single-bit operations, the words a range spans, and for a find the
// words scanned up to the hit (at most ceil(bytes in use / 4), 32 for a
// 128-byte map). The single read port of the word memory reads one word per
// cycle; a previous result still stalled in the output register holds back
// the final result load. The map reads as all free after reset without any
// clearing pass. A new item is taken while the previous result still waits
// in the output register.
module bitmap_run_allocator_top #(
    parameter int MAP_BYTES = 128
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [bra_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               opcode,
    input  logic [bra_pkg::POS_W-1:0] bit_pos,
    input  logic [bra_pkg::CNT_W-1:0] bit_count,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     bit_value,
    output logic                     found,
    output logic [bra_pkg::POS_W-1:0] run_start,
    output logic                     error
);
    import bra_pkg::*;

    bra_cmd_t    cmd;
    bra_status_t status;

    // sequencer
    bra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // map store and word processing
    bra_datapath #(
        .MAP_BYTES (MAP_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opcode      (opcode),
        .bit_pos     (bit_pos),
        .bit_count   (bit_count),
        .cmd         (cmd),
        .status      (status),
        .bit_value   (bit_value),
        .found       (found),
        .run_start   (run_start),
        .error       (error)
    );

endmodule
